>>> hdl/ogcu_pkg.sv
// Shared constants, codes and types of the occupancy grid confidence update block.
package ogcu_pkg;

   localparam int CMD_W   = 2;
   localparam int COORD_W = 6;
   localparam int VALUE_W = 7;
   localparam int Q8_W    = 16;
   localparam int PCT_W   = 7;

   localparam logic [CMD_W-1:0] CMD_MARK  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SWEEP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;
   localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

   localparam logic [VALUE_W-1:0] CONF_RESET = 7'd50;
   localparam logic [VALUE_W-1:0] CONF_MIN   = 7'd1;
   localparam logic [VALUE_W-1:0] CONF_MAX   = 7'd99;
   localparam logic [PCT_W-1:0]   PCT_FULL   = 7'd100;

   localparam int REG_IDX_W = 3;
   localparam logic [REG_IDX_W-1:0] REG_CPM     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_HIT     = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_MISS    = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_FLOOR   = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_REPLACE = 3'd4;

   localparam logic [Q8_W-1:0]  CPM_RESET     = 16'd256;
   localparam logic [PCT_W-1:0] HIT_RESET     = 7'd60;
   localparam logic [PCT_W-1:0] MISS_RESET    = 7'd30;
   localparam logic [PCT_W-1:0] FLOOR_RESET   = 7'd10;
   localparam logic [PCT_W-1:0] REPLACE_RESET = 7'd20;

   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam int QUEUE_DEPTH = 4;

   typedef struct packed {
      logic [Q8_W-1:0]  cells_per_metre_q8;
      logic [PCT_W-1:0] hit_percent;
      logic [PCT_W-1:0] miss_percent;
      logic [PCT_W-1:0] miss_floor;
      logic [PCT_W-1:0] floor_replacement;
   } cfg_type;

endpackage

>>> hdl/ogcu_if.sv
// Valid/ready channel interfaces for command items and result items.
interface ogcu_req_if import ogcu_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CMD_W-1:0]        command;
   logic signed [Q8_W-1:0]  forward_q8;
   logic signed [Q8_W-1:0]  lateral_q8;
   logic [COORD_W-1:0]      read_row;
   logic [COORD_W-1:0]      read_col;

   modport source (output valid, command, forward_q8, lateral_q8, read_row, read_col,
                   input ready);
   modport sink (input valid, command, forward_q8, lateral_q8, read_row, read_col,
                 output ready);
endinterface

interface ogcu_rsp_if import ogcu_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] cell_row;
   logic [COORD_W-1:0] cell_col;
   logic [VALUE_W-1:0] cell_value;
   logic               sweep_done;

   modport source (output valid, cell_row, cell_col, cell_value, sweep_done, input ready);
   modport sink (input valid, cell_row, cell_col, cell_value, sweep_done, output ready);
endinterface

>>> hdl/ogcu_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ogcu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/ogcu_queue.sv
// Small first-in first-out queue between the front and back parts.
module ogcu_queue import ogcu_pkg::*; #(
   parameter int WIDTH = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PW:0]      count_ff, count_in;
   logic             push, pop;

   assign push_ready = (count_ff != (PW+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> hdl/ogcu_fuse.sv
// Multi-cycle Bayesian fusion unit: floor(100*p*q / (p*q + (100-p)*(100-q))), clamped to 1..99.
module ogcu_fuse import ogcu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PCT_W-1:0]   p,
   input  logic [PCT_W-1:0]   q,
   output logic               done,
   output logic [VALUE_W-1:0] result
);

   localparam int PROD_W = 14;
   localparam int DEN_W  = 15;
   localparam int NUM_W  = 20;
   localparam int DVS_W  = 21;
   localparam int QUO_W  = 7;

   logic               busy_ff, busy_in;
   logic [2:0]         step_ff, step_in;
   logic [PROD_W-1:0]  pq_ff, npq_ff;
   logic [NUM_W-1:0]   rem_ff, rem_in;
   logic [DVS_W-1:0]   dvs_ff, dvs_in;
   logic [QUO_W-1:0]   quo_ff, quo_in;
   logic               den_zero_ff;
   logic [DEN_W-1:0]   den;
   logic [PCT_W-1:0]   p_sat, q_sat;
   logic               done_ff, done_in;
   logic [VALUE_W-1:0] result_ff, result_in;
   logic               ge;

   assign p_sat = (p > PCT_FULL) ? PCT_FULL : p;
   assign q_sat = (q > PCT_FULL) ? PCT_FULL : q;
   assign den   = DEN_W'(pq_ff) + DEN_W'(npq_ff);
   assign ge    = ({1'b0, rem_ff} >= dvs_ff);

   // Step zero forms numerator and divisor; steps one to seven each resolve one quotient bit.
   always_comb begin
      busy_in   = busy_ff;
      step_in   = step_ff;
      rem_in    = rem_ff;
      dvs_in    = dvs_ff;
      quo_in    = quo_ff;
      done_in   = 1'b0;
      result_in = result_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
      end else if (busy_ff) begin
         if (step_ff == '0) begin
            rem_in  = NUM_W'(pq_ff) * NUM_W'(100);
            dvs_in  = {DVS_W'(den)} << (QUO_W - 1);
            quo_in  = '0;
            step_in = 3'd1;
         end else begin
            if (ge) begin
               rem_in = rem_ff - dvs_ff[NUM_W-1:0];
            end
            quo_in = {quo_ff[QUO_W-2:0], ge};
            dvs_in = dvs_ff >> 1;
            if (step_ff == 3'd7) begin
               busy_in = 1'b0;
               done_in = 1'b1;
               if (den_zero_ff || quo_in < CONF_MIN) begin
                  result_in = CONF_MIN;
               end else if (quo_in > CONF_MAX) begin
                  result_in = CONF_MAX;
               end else begin
                  result_in = quo_in;
               end
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff   <= step_in;
      rem_ff    <= rem_in;
      dvs_ff    <= dvs_in;
      quo_ff    <= quo_in;
      result_ff <= result_in;
      if (start) begin
         pq_ff  <= PROD_W'(p_sat) * PROD_W'(q_sat);
         npq_ff <= PROD_W'(PCT_FULL - p_sat) * PROD_W'(PCT_FULL - q_sat);
      end
      if (busy_ff && step_ff == '0) begin
         den_zero_ff <= (den == '0);
      end
   end

   assign done   = done_ff;
   assign result = result_ff;

endmodule

>>> hdl/ogcu_front.sv
// Front part: accepts command items and maps obstacle points to grid cells in two stages.
module ogcu_front import ogcu_pkg::*; #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64,
   localparam int RW = $clog2(GRID_ROWS),
   localparam int CW = $clog2(GRID_COLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             accept_en,
   input  logic [Q8_W-1:0]  cells_per_metre_q8,
   ogcu_req_if.sink         req,
   output logic             push_valid,
   input  logic             push_ready,
   output logic [CMD_W-1:0] push_cmd,
   output logic [RW-1:0]    push_row,
   output logic [CW-1:0]    push_col
);

   localparam int RND_W = Q8_W + 1;
   localparam int SUM_W = 2 * Q8_W + 1;
   localparam logic [SUM_W-1:0] ROUND_HALF = SUM_W'(1) << (Q8_W - 1);
   localparam logic [RND_W-1:0] ROW_LAST = RND_W'(GRID_ROWS - 1);
   localparam logic [RND_W-1:0] COL_HALF = RND_W'(GRID_COLS / 2);
   localparam logic [RND_W:0]   COL_LAST = (RND_W+1)'(GRID_COLS - 1);

   logic               accept, s2_free, s1_move;
   logic               s1_v_ff, s1_v_in, s2_v_ff, s2_v_in;
   logic [CMD_W-1:0]   s1_cmd_ff, s2_cmd_ff;
   logic               s1_fneg_ff, s1_lneg_ff, s2_fneg_ff, s2_lneg_ff;
   logic [Q8_W-1:0]    s1_fmag_ff, s1_lmag_ff, fmag_in, lmag_in, f_bits, l_bits;
   logic [RW-1:0]      s1_rrow_ff, s2_rrow_ff, rrow_in, row_mark;
   logic [CW-1:0]      s1_rcol_ff, s2_rcol_ff, rcol_in, col_mark;
   logic [2*Q8_W-1:0]  s2_fprod_ff, s2_lprod_ff;
   logic [SUM_W-1:0]   fsum, lsum;
   logic [RND_W-1:0]   frnd, lrnd;
   logic [RND_W:0]     csum;

   assign s2_free   = !s2_v_ff || push_ready;
   assign req.ready = accept_en && (!s1_v_ff || s2_free);
   assign accept    = req.valid && req.ready;
   assign s1_move   = s1_v_ff && s2_free;
   assign s1_v_in   = accept || (s1_v_ff && !s2_free);
   assign s2_v_in   = s1_move || (s2_v_ff && !push_ready);

   always_comb begin
      f_bits  = req.forward_q8;
      l_bits  = req.lateral_q8;
      fmag_in = f_bits[Q8_W-1] ? (~f_bits + 1'b1) : f_bits;
      lmag_in = l_bits[Q8_W-1] ? (~l_bits + 1'b1) : l_bits;
      rrow_in = (32'(req.read_row) > GRID_ROWS - 1) ? RW'(GRID_ROWS - 1) : RW'(req.read_row);
      rcol_in = (32'(req.read_col) > GRID_COLS - 1) ? CW'(GRID_COLS - 1) : CW'(req.read_col);
   end

   // Round half away from zero on the magnitude, then clamp into the grid.
   always_comb begin
      fsum = {1'b0, s2_fprod_ff} + ROUND_HALF;
      lsum = {1'b0, s2_lprod_ff} + ROUND_HALF;
      frnd = fsum[SUM_W-1:Q8_W];
      lrnd = lsum[SUM_W-1:Q8_W];
      csum = {1'b0, lrnd} + {1'b0, COL_HALF};
      if (s2_fneg_ff) begin
         row_mark = '0;
      end else if (frnd > ROW_LAST) begin
         row_mark = RW'(GRID_ROWS - 1);
      end else begin
         row_mark = RW'(frnd);
      end
      if (s2_lneg_ff) begin
         col_mark = (lrnd > COL_HALF) ? '0 : CW'(COL_HALF - lrnd);
      end else begin
         col_mark = (csum > COL_LAST) ? CW'(GRID_COLS - 1) : CW'(csum);
      end
   end

   assign push_valid = s2_v_ff;
   assign push_cmd   = s2_cmd_ff;
   assign push_row   = (s2_cmd_ff == CMD_READ) ? s2_rrow_ff : row_mark;
   assign push_col   = (s2_cmd_ff == CMD_READ) ? s2_rcol_ff : col_mark;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
      end
      if (accept) begin
         s1_cmd_ff  <= req.command;
         s1_fneg_ff <= f_bits[Q8_W-1];
         s1_lneg_ff <= l_bits[Q8_W-1];
         s1_fmag_ff <= fmag_in;
         s1_lmag_ff <= lmag_in;
         s1_rrow_ff <= rrow_in;
         s1_rcol_ff <= rcol_in;
      end
      if (s1_move) begin
         s2_cmd_ff   <= s1_cmd_ff;
         s2_fneg_ff  <= s1_fneg_ff;
         s2_lneg_ff  <= s1_lneg_ff;
         s2_fprod_ff <= s1_fmag_ff * cells_per_metre_q8;
         s2_lprod_ff <= s1_lmag_ff * cells_per_metre_q8;
         s2_rrow_ff  <= s1_rrow_ff;
         s2_rcol_ff  <= s1_rcol_ff;
      end
   end

endmodule

>>> hdl/ogcu_back.sv
// Back part: carries out marks, reads and end-of-scan sweeps on the grid memories.
module ogcu_back import ogcu_pkg::*; #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64,
   localparam int RW = $clog2(GRID_ROWS),
   localparam int CW = $clog2(GRID_COLS)
) (
   input  logic             clock,
   input  logic             reset,
   input  cfg_type          cfg,
   input  logic             item_valid,
   output logic             item_ready,
   input  logic [CMD_W-1:0] item_cmd,
   input  logic [RW-1:0]    item_row,
   input  logic [CW-1:0]    item_col,
   output logic             clearing,
   ogcu_rsp_if.source       rsp
);

   localparam int CELLS = GRID_ROWS * GRID_COLS;
   localparam int AW    = $clog2(CELLS);
   localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);

   localparam logic [2:0] ST_CLEAR   = 3'd0;
   localparam logic [2:0] ST_IDLE    = 3'd1;
   localparam logic [2:0] ST_READ    = 3'd2;
   localparam logic [2:0] ST_SW_ADDR = 3'd3;
   localparam logic [2:0] ST_SW_DATA = 3'd4;
   localparam logic [2:0] ST_SW_FUSE = 3'd5;

   logic [2:0]         state_ff, state_in;
   logic [AW-1:0]      idx_ff, idx_in, head_addr;
   logic [RW-1:0]      hold_row_ff;
   logic [CW-1:0]      hold_col_ff;
   logic               mark_bit_ff;
   logic               rsp_valid_ff, rsp_valid_in, rsp_load;
   logic [COORD_W-1:0] rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   logic [VALUE_W-1:0] rsp_val_ff, rsp_val_in;
   logic               rsp_done_ff, rsp_done_in;
   logic               pop, cell_write;
   logic               conf_wr, conf_rd, mark_wr, mark_rd;
   logic [AW-1:0]      mark_wr_addr, conf_rd_addr;
   logic [VALUE_W-1:0] conf_wr_data, conf_q, sweep_val, rep_sat;
   logic               mark_wr_data, mark_q;
   logic               fuse_start, fuse_done;
   logic [VALUE_W-1:0] fuse_result;

   assign head_addr  = AW'(item_row) * AW'(GRID_COLS) + AW'(item_col);
   assign item_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign pop        = item_valid && item_ready;
   assign clearing   = (state_ff == ST_CLEAR);
   assign cell_write = (state_ff == ST_SW_FUSE) && fuse_done;
   assign fuse_start = (state_ff == ST_SW_DATA);

   always_comb begin
      if (cfg.floor_replacement < CONF_MIN) begin
         rep_sat = CONF_MIN;
      end else if (cfg.floor_replacement > CONF_MAX) begin
         rep_sat = CONF_MAX;
      end else begin
         rep_sat = cfg.floor_replacement;
      end
      sweep_val = (!mark_bit_ff && fuse_result < cfg.miss_floor) ? rep_sat : fuse_result;
   end

   always_comb begin
      conf_wr      = clearing || cell_write;
      conf_wr_data = clearing ? CONF_RESET : sweep_val;
      conf_rd      = (pop && item_cmd == CMD_READ) || (state_ff == ST_SW_ADDR);
      conf_rd_addr = (state_ff == ST_IDLE) ? head_addr : idx_ff;
      mark_wr      = clearing || cell_write || (pop && item_cmd == CMD_MARK);
      mark_wr_addr = (state_ff == ST_IDLE) ? head_addr : idx_ff;
      mark_wr_data = (state_ff == ST_IDLE);
      mark_rd      = (state_ff == ST_SW_ADDR);
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      rsp_load    = 1'b0;
      rsp_row_in  = '0;
      rsp_col_in  = '0;
      rsp_val_in  = '0;
      rsp_done_in = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            if (idx_ff == LAST_CELL) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (pop) begin
               unique case (item_cmd)
                  CMD_MARK: begin
                     rsp_load   = 1'b1;
                     rsp_row_in = COORD_W'(item_row);
                     rsp_col_in = COORD_W'(item_col);
                  end
                  CMD_SWEEP: begin
                     idx_in   = '0;
                     state_in = ST_SW_ADDR;
                  end
                  CMD_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_load   = 1'b1;
            rsp_row_in = COORD_W'(hold_row_ff);
            rsp_col_in = COORD_W'(hold_col_ff);
            rsp_val_in = conf_q;
            state_in   = ST_IDLE;
         end
         ST_SW_ADDR: begin
            state_in = ST_SW_DATA;
         end
         ST_SW_DATA: begin
            state_in = ST_SW_FUSE;
         end
         ST_SW_FUSE: begin
            if (fuse_done) begin
               if (idx_ff == LAST_CELL) begin
                  idx_in      = '0;
                  rsp_load    = 1'b1;
                  rsp_done_in = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = ST_SW_ADDR;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (pop) begin
         hold_row_ff <= item_row;
         hold_col_ff <= item_col;
      end
      if (state_ff == ST_SW_DATA) begin
         mark_bit_ff <= mark_q;
      end
      if (rsp_load) begin
         rsp_row_ff  <= rsp_row_in;
         rsp_col_ff  <= rsp_col_in;
         rsp_val_ff  <= rsp_val_in;
         rsp_done_ff <= rsp_done_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.cell_row   = rsp_row_ff;
   assign rsp.cell_col   = rsp_col_ff;
   assign rsp.cell_value = rsp_val_ff;
   assign rsp.sweep_done = rsp_done_ff;

   ogcu_ram #(.WIDTH(VALUE_W), .DEPTH(CELLS)) u_conf_ram (
      .clock   (clock),
      .wr_en   (conf_wr),
      .wr_addr (idx_ff),
      .wr_data (conf_wr_data),
      .rd_en   (conf_rd),
      .rd_addr (conf_rd_addr),
      .rd_data (conf_q)
   );

   ogcu_ram #(.WIDTH(1), .DEPTH(CELLS)) u_mark_ram (
      .clock   (clock),
      .wr_en   (mark_wr),
      .wr_addr (mark_wr_addr),
      .wr_data (mark_wr_data),
      .rd_en   (mark_rd),
      .rd_addr (idx_ff),
      .rd_data (mark_q)
   );

   ogcu_fuse u_fuse (
      .clock  (clock),
      .reset  (reset),
      .start  (fuse_start),
      .p      (conf_q),
      .q      (mark_q ? cfg.hit_percent : cfg.miss_percent),
      .done   (fuse_done),
      .result (fuse_result)
   );

endmodule

>>> hdl/occupancy_grid_confidence_update.sv
// Occupancy grid confidence update: mark points, fuse confidences at end of scan, read cells.
// After reset the block runs a clearing pass that sets every cell to 50 percent and clears the
// hit marks; no command is taken during it, while register writes are. A mark or read command
// is taken every cycle while the queue has room and flows through a two-stage front end (point
// scaling multiplier, then rounding and clamping) into a four-entry queue. The back end
// executes one command at a time: a mark is answered from the idle state, a read after a
// registered memory read in the read state. An end-of-scan command walks every cell, one at a
// time, through the shared iterative fusion divider and gives its result after the last cell.
// Registers: 0 cells_per_metre_q8, 1 hit_percent, 2 miss_percent, 3 miss_floor,
// 4 floor_replacement, at byte addresses 4*index; write them only while the block is idle.
module occupancy_grid_confidence_update import ogcu_pkg::*; #(
   parameter int GRID_ROWS = 64,
   parameter int GRID_COLS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   ogcu_req_if.sink              req_chan,
   ogcu_rsp_if.source            rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   localparam int RW = $clog2(GRID_ROWS);
   localparam int CW = $clog2(GRID_COLS);
   localparam int QW = CMD_W + RW + CW;

   cfg_type                cfg_ff;
   logic [REG_IDX_W-1:0]   reg_idx;
   logic                   csr_write, clearing;
   logic                   push_valid, push_ready, pop_valid, pop_ready;
   logic [CMD_W-1:0]       push_cmd;
   logic [RW-1:0]          push_row;
   logic [CW-1:0]          push_col;
   logic [QW-1:0]          pop_data;

   assign pready    = 1'b1;
   assign reg_idx   = paddr[CSR_ADDR_W-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cells_per_metre_q8 <= CPM_RESET;
         cfg_ff.hit_percent        <= HIT_RESET;
         cfg_ff.miss_percent       <= MISS_RESET;
         cfg_ff.miss_floor         <= FLOOR_RESET;
         cfg_ff.floor_replacement  <= REPLACE_RESET;
      end else if (csr_write) begin
         unique case (reg_idx)
            REG_CPM:     cfg_ff.cells_per_metre_q8 <= pwdata[Q8_W-1:0];
            REG_HIT:     cfg_ff.hit_percent        <= pwdata[PCT_W-1:0];
            REG_MISS:    cfg_ff.miss_percent       <= pwdata[PCT_W-1:0];
            REG_FLOOR:   cfg_ff.miss_floor         <= pwdata[PCT_W-1:0];
            REG_REPLACE: cfg_ff.floor_replacement  <= pwdata[PCT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_CPM:     prdata = CSR_DATA_W'(cfg_ff.cells_per_metre_q8);
         REG_HIT:     prdata = CSR_DATA_W'(cfg_ff.hit_percent);
         REG_MISS:    prdata = CSR_DATA_W'(cfg_ff.miss_percent);
         REG_FLOOR:   prdata = CSR_DATA_W'(cfg_ff.miss_floor);
         REG_REPLACE: prdata = CSR_DATA_W'(cfg_ff.floor_replacement);
         default:     prdata = '0;
      endcase
   end

   ogcu_front #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .accept_en          (!clearing),
      .cells_per_metre_q8 (cfg_ff.cells_per_metre_q8),
      .req                (req_chan),
      .push_valid         (push_valid),
      .push_ready         (push_ready),
      .push_cmd           (push_cmd),
      .push_row           (push_row),
      .push_col           (push_col)
   );

   ogcu_queue #(.WIDTH(QW)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  ({push_cmd, push_row, push_col}),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   ogcu_back #(.GRID_ROWS(GRID_ROWS), .GRID_COLS(GRID_COLS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_valid (pop_valid),
      .item_ready (pop_ready),
      .item_cmd   (pop_data[QW-1:RW+CW]),
      .item_row   (pop_data[RW+CW-1:CW]),
      .item_col   (pop_data[CW-1:0]),
      .clearing   (clearing),
      .rsp        (rsp_chan)
   );

   // No command may enter while the grid is still being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !(req_chan.valid && req_chan.ready))
      else $error("command transfer during clearing pass");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.sweep_done) |->
         (rsp_chan.cell_row == '0 && rsp_chan.cell_col == '0 && rsp_chan.cell_value == '0))
      else $error("sweep result carries a cell");

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.cell_value <= CONF_MAX))
      else $error("confidence out of range");

   // A result register that is not taken keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=>
         (rsp_chan.valid && $stable(rsp_chan.cell_value) && $stable(rsp_chan.sweep_done)))
      else $error("pending result changed");

endmodule

>>> sim/tb.sv
// Self-checking testbench for the occupancy grid confidence update block.
module tb;
   import ogcu_pkg::*;

   localparam int ROWS = 64;
   localparam int COLS = 64;
   localparam int CELLS = ROWS * COLS;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int HOLD_CYCLES = 400;

   typedef struct {
      logic [CMD_W-1:0]       command;
      logic signed [Q8_W-1:0] forward_q8;
      logic signed [Q8_W-1:0] lateral_q8;
      logic [COORD_W-1:0]     read_row;
      logic [COORD_W-1:0]     read_col;
   } grid_cmd_type;

   typedef struct {
      logic [COORD_W-1:0] cell_row;
      logic [COORD_W-1:0] cell_col;
      logic [VALUE_W-1:0] cell_value;
      logic               sweep_done;
   } grid_rsp_type;

   logic clock;
   logic reset;
   logic psel, penable, pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   ogcu_req_if req_chan ();
   ogcu_rsp_if rsp_chan ();

   occupancy_grid_confidence_update dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   // Shadow copy of the grid and the registers.
   logic [VALUE_W-1:0] grid_conf [CELLS];
   bit                 grid_hit  [CELLS];
   logic [Q8_W-1:0]    cpm;
   logic [PCT_W-1:0]   hit_pct, miss_pct, floor_pct, replace_pct;

   grid_cmd_type pending_cmds [$];
   grid_rsp_type awaited_rsps [$];
   grid_cmd_type cur_cmd;

   int  errors;
   int  n_marks, n_reads, n_sweeps, n_other, n_rsps;
   bit  no_idle;
   bit  hold_wanted, hold_done;
   int  hold_left;
   int  quiet_cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic longint to_cells(logic signed [Q8_W-1:0] v);
      longint mag, r;
      mag = (v < 0) ? -longint'(v) : longint'(v);
      r = (mag * longint'(cpm) + 32768) >>> 16;
      return (v < 0) ? -r : r;
   endfunction

   function automatic int unsigned bayes_fuse(int unsigned p, int unsigned q);
      int unsigned num, den, r;
      if (p > 100) p = 100;
      if (q > 100) q = 100;
      num = 100 * p * q;
      den = p * q + (100 - p) * (100 - q);
      r = (den != 0) ? num / den : 0;
      if (r < 1) r = 1;
      if (r > 99) r = 99;
      return r;
   endfunction

   // Applies one accepted command to the shadow grid and queues its response.
   task automatic apply_grid_cmd(grid_cmd_type c);
      grid_rsp_type rsp;
      longint r, k;
      int unsigned rep, v;
      rsp = '{default: '0};
      case (c.command)
         CMD_MARK: begin
            r = to_cells(c.forward_q8);
            k = to_cells(c.lateral_q8) + COLS / 2;
            r = (r < 0) ? 0 : ((r > ROWS - 1) ? ROWS - 1 : r);
            k = (k < 0) ? 0 : ((k > COLS - 1) ? COLS - 1 : k);
            grid_hit[r * COLS + k] = 1'b1;
            rsp.cell_row = COORD_W'(r);
            rsp.cell_col = COORD_W'(k);
            n_marks++;
         end
         CMD_SWEEP: begin
            rep = replace_pct;
            if (rep < 1) rep = 1;
            if (rep > 99) rep = 99;
            for (int i = 0; i < CELLS; i++) begin
               if (grid_hit[i]) begin
                  v = bayes_fuse(grid_conf[i], hit_pct);
               end else begin
                  v = bayes_fuse(grid_conf[i], miss_pct);
                  if (v < floor_pct) v = rep;
               end
               grid_conf[i] = VALUE_W'(v);
               grid_hit[i] = 1'b0;
            end
            rsp.sweep_done = 1'b1;
            n_sweeps++;
         end
         CMD_READ: begin
            rsp.cell_row = c.read_row;
            rsp.cell_col = c.read_col;
            rsp.cell_value = grid_conf[int'(c.read_row) * COLS + int'(c.read_col)];
            n_reads++;
         end
         default: n_other++;
      endcase
      awaited_rsps.insert(awaited_rsps.size(), rsp);
   endtask

   // Driver: offers queued commands, idling now and then.
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) apply_grid_cmd(cur_cmd);
         if (!req_chan.valid || req_chan.ready) begin
            if (pending_cmds.size() > 0 && (no_idle || $urandom_range(99) >= 8)) begin
               cur_cmd = pending_cmds.pop_front();
               req_chan.valid      <= 1'b1;
               req_chan.command    <= cur_cmd.command;
               req_chan.forward_q8 <= cur_cmd.forward_q8;
               req_chan.lateral_q8 <= cur_cmd.lateral_q8;
               req_chan.read_row   <= cur_cmd.read_row;
               req_chan.read_col   <= cur_cmd.read_col;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_chan.ready <= 1'b0;
      end else if (hold_wanted && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= no_idle || ($urandom_range(99) >= 8);
      end
   end

   // Monitor: compares each response transfer with the oldest prediction.
   always @(posedge clock) begin
      grid_rsp_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         n_rsps++;
         if (awaited_rsps.size() == 0) begin
            $display("%0t: unexpected response row %0d col %0d value %0d done %0b", $time,
                     rsp_chan.cell_row, rsp_chan.cell_col, rsp_chan.cell_value,
                     rsp_chan.sweep_done);
            errors++;
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_chan.cell_row !== want.cell_row) begin
               $display("%0t: cell_row expected %0d actual %0d", $time, want.cell_row,
                        rsp_chan.cell_row);
               errors++;
            end
            if (rsp_chan.cell_col !== want.cell_col) begin
               $display("%0t: cell_col expected %0d actual %0d", $time, want.cell_col,
                        rsp_chan.cell_col);
               errors++;
            end
            if (rsp_chan.cell_value !== want.cell_value) begin
               $display("%0t: cell_value expected %0d actual %0d", $time, want.cell_value,
                        rsp_chan.cell_value);
               errors++;
            end
            if (rsp_chan.sweep_done !== want.sweep_done) begin
               $display("%0t: sweep_done expected %0b actual %0b", $time, want.sweep_done,
                        rsp_chan.sweep_done);
               errors++;
            end
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic csr_write(logic [REG_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_W'(idx) << 2;
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         REG_CPM:     cpm = value[Q8_W-1:0];
         REG_HIT:     hit_pct = value[PCT_W-1:0];
         REG_MISS:    miss_pct = value[PCT_W-1:0];
         REG_FLOOR:   floor_pct = value[PCT_W-1:0];
         REG_REPLACE: replace_pct = value[PCT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic set_regs(int c, int h, int m, int f, int r);
      csr_write(REG_CPM, c);
      csr_write(REG_HIT, h);
      csr_write(REG_MISS, m);
      csr_write(REG_FLOOR, f);
      csr_write(REG_REPLACE, r);
   endtask

   task automatic push_cmd(logic [CMD_W-1:0] op, int fwd, int lat, int rr, int rc);
      grid_cmd_type c;
      c.command    = op;
      c.forward_q8 = Q8_W'(fwd);
      c.lateral_q8 = Q8_W'(lat);
      c.read_row   = COORD_W'(rr);
      c.read_col   = COORD_W'(rc);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // Waits until every prediction has been met, then lets the block settle.
   task automatic drain();
      do @(posedge clock);
      while (pending_cmds.size() > 0 || req_chan.valid || awaited_rsps.size() > 0);
      repeat (10) @(posedge clock);
   endtask

   task automatic random_cmds(int count);
      int sel;
      for (int i = 0; i < count; i++) begin
         sel = $urandom_range(999);
         if (sel < 3) begin
            push_cmd(CMD_SWEEP, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 20) begin
            push_cmd(CMD_NONE, $urandom, $urandom, $urandom, $urandom);
         end else if (sel < 600) begin
            if ($urandom_range(9) < 7)
               push_cmd(CMD_MARK, $urandom_range(16383) - 512, $urandom_range(16383) - 8192,
                        $urandom, $urandom);
            else
               push_cmd(CMD_MARK, $urandom, $urandom, $urandom, $urandom);
         end else begin
            push_cmd(CMD_READ, $urandom, $urandom, $urandom, $urandom);
         end
      end
      // Every phase ends its scan so the current settings reach the fusion.
      push_cmd(CMD_SWEEP, 0, 0, 0, 0);
      for (int i = 0; i < 8; i++) push_cmd(CMD_READ, 0, 0, $urandom, $urandom);
   endtask

   initial begin
      reset = 1'b1;
      psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
      req_chan.valid = 1'b0; req_chan.command = CMD_MARK; req_chan.forward_q8 = '0;
      req_chan.lateral_q8 = '0; req_chan.read_row = '0; req_chan.read_col = '0;
      rsp_chan.ready = 1'b0;
      errors = 0; n_marks = 0; n_reads = 0; n_sweeps = 0; n_other = 0; n_rsps = 0;
      no_idle = 1'b0; hold_wanted = 1'b0; hold_done = 1'b0; hold_left = 0; quiet_cycles = 0;
      for (int i = 0; i < CELLS; i++) begin
         grid_conf[i] = CONF_RESET;
         grid_hit[i] = 1'b0;
      end
      cpm = CPM_RESET; hit_pct = HIT_RESET; miss_pct = MISS_RESET;
      floor_pct = FLOOR_RESET; replace_pct = REPLACE_RESET;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, rounding at half a cell, negative rows, every command.
      push_cmd(CMD_MARK, 32767, 32767, 0, 0);
      push_cmd(CMD_MARK, -32768, -32768, 0, 0);
      push_cmd(CMD_MARK, 0, 0, 0, 0);
      push_cmd(CMD_MARK, 128, 128, 0, 0);
      push_cmd(CMD_MARK, 127, 127, 0, 0);
      push_cmd(CMD_MARK, -128, -128, 0, 0);
      push_cmd(CMD_MARK, -129, -8320, 0, 0);
      push_cmd(CMD_NONE, -1, -1, 63, 63);
      push_cmd(CMD_READ, 0, 0, 0, 0);
      push_cmd(CMD_READ, 0, 0, 63, 63);
      push_cmd(CMD_SWEEP, 0, 0, 0, 0);
      push_cmd(CMD_READ, 0, 0, 0, 32);
      push_cmd(CMD_READ, 0, 0, 1, 33);
      push_cmd(CMD_READ, 0, 0, 63, 63);
      push_cmd(CMD_READ, 0, 0, 5, 5);
      drain();

      // Phase with the long response hold-off and no random idling.
      no_idle = 1'b1;
      hold_wanted = 1'b1;
      random_cmds(250);
      drain();
      no_idle = 1'b0;

      set_regs(1, 99, 1, 99, 1);
      random_cmds(250);
      drain();
      set_regs(65535, 1, 99, 0, 99);
      random_cmds(250);
      drain();
      set_regs(512, 127, 0, 127, 0);
      random_cmds(250);
      drain();
      set_regs(300, 0, 127, 50, 127);
      random_cmds(250);
      drain();
      set_regs($urandom_range(65535, 1), $urandom_range(99, 1), $urandom_range(99, 1),
               $urandom_range(99), $urandom_range(99, 1));
      random_cmds(250);
      drain();
      set_regs(CPM_RESET, HIT_RESET, MISS_RESET, FLOOR_RESET, REPLACE_RESET);
      random_cmds(250);
      drain();
      repeat (50) @(posedge clock);

      $display("Run covered %0d marks, %0d reads, %0d sweeps and %0d unused commands;",
               n_marks, n_reads, n_sweeps, n_other);
      $display("%0d responses checked over seven register settings, %0d errors.", n_rsps,
               errors);
      if (errors == 0 && awaited_rsps.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

>>> sim.f
hdl/ogcu_pkg.sv
hdl/ogcu_if.sv
hdl/ogcu_ram.sv
hdl/ogcu_queue.sv
hdl/ogcu_fuse.sv
hdl/ogcu_front.sv
hdl/ogcu_back.sv
hdl/occupancy_grid_confidence_update.sv
sim/tb.sv
